[rtl/sfp_pkg.sv]
// Shared constants for the sync frame parser with Fletcher-8 checksum.
// No dependencies; the interfaces, the parser and the bench import this package.
`timescale 1ns / 1ps

package sfp_pkg;

  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int FLEN_W   = 7;
  localparam int INDEX_W  = 6;

  // Sync pair that opens every frame
  localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hB5;
  localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h62;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_GOOD     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_CKSUM    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_TOO_LONG = 2'd2;

endpackage

[rtl/sfp_byte_if.sv]
// Valid/ready channel carrying one received serial byte per beat.
// Depends on sfp_pkg for the byte width.
`timescale 1ns / 1ps

interface sfp_byte_if;
  import sfp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

[rtl/sfp_result_if.sv]
// Valid/ready channel carrying one parser result per beat.
// Depends on sfp_pkg for field widths.
`timescale 1ns / 1ps

interface sfp_result_if;
  import sfp_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BYTE_W-1:0]   frame_class;
  logic [BYTE_W-1:0]   msg_id;
  logic [FLEN_W-1:0]   frame_len;
  logic [INDEX_W-1:0]  byte_index;
  logic [BYTE_W-1:0]   payload_byte;
  logic                byte_valid;
  logic                last;

  modport source (output valid, output status, output frame_class, output msg_id,
                  output frame_len, output byte_index, output payload_byte,
                  output byte_valid, output last, input ready);
  modport sink (input valid, input status, input frame_class, input msg_id,
                input frame_len, input byte_index, input payload_byte,
                input byte_valid, input last, output ready);
endinterface

[rtl/sync_frame_parser_fletcher_checksum.sv]
// Sync frame parser with Fletcher-8 checksum. Takes one serial byte per beat
// while parsing: it hunts for the sync pair B5 62, reads class, id and a
// little-endian 16-bit length, stores up to MAX_PAYLOAD payload bytes in an
// on-chip RAM and checks the two Fletcher-8 bytes. A good frame of N payload
// bytes comes out as N result beats (one for an empty frame); a checksum
// failure or an oversize length gives one error beat. Parsing runs at one
// byte per cycle; while a result waits in the output register and the sink
// is not ready, no byte is taken. Emitting a good frame goes through ST_READ
// for the first RAM read, then per byte ST_LOAD to load the output register
// and ST_WAIT to present the beat while the next byte is read; no byte is
// taken during emission, and ST_WAIT holds while the sink is not ready.
// The payload RAM needs no clearing after reset.
`timescale 1ns / 1ps

module sync_frame_parser_fletcher_checksum #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic         clk,
  input  logic         rst,
  sfp_byte_if.sink     rx,
  sfp_result_if.source frame_out
);
  import sfp_pkg::*;

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int CW = $clog2(MAX_PAYLOAD + 1);

  typedef enum logic [3:0] {
    PH_SYNC1, PH_SYNC2, PH_CLASS, PH_ID, PH_LEN1, PH_LEN2,
    PH_PAYLOAD, PH_CKA, PH_CKB
  } phase_t;

  typedef enum logic [1:0] {
    ST_PARSE, ST_READ, ST_LOAD, ST_WAIT
  } ctl_state_t;

  ctl_state_t ctl_state, ctl_state_next;
  phase_t     parse_phase, parse_phase_next;

  logic [BYTE_W-1:0] class_reg, class_reg_next;
  logic [BYTE_W-1:0] id_reg, id_reg_next;
  logic [BYTE_W-1:0] len_lo, len_lo_next;
  logic [CW-1:0]     frame_length, frame_length_next;
  logic [BYTE_W-1:0] sum_a, sum_a_next;
  logic [BYTE_W-1:0] sum_b, sum_b_next;
  logic [CW-1:0]     fill_count, fill_count_next;
  logic [CW-1:0]     rd_idx, rd_idx_next;

  logic                out_valid, out_valid_next;
  logic [STATUS_W-1:0] out_status, out_status_next;
  logic [FLEN_W-1:0]   out_flen, out_flen_next;
  logic [INDEX_W-1:0]  out_index, out_index_next;
  logic [BYTE_W-1:0]   out_data, out_data_next;
  logic                out_bvalid, out_bvalid_next;
  logic                out_last, out_last_next;

  logic              in_fire;
  logic              out_fire;
  logic [BYTE_W-1:0] b;
  logic [BYTE_W-1:0] fold_a;
  logic [15:0]       full_len;
  logic [CW-1:0]     fill_inc;
  logic [CW-1:0]     rd_inc;

  logic              ram_wr_en;
  logic              ram_rd_en;
  logic [AW-1:0]     ram_rd_addr;
  logic [BYTE_W-1:0] ram_rd_data;

  // Handshakes: take a byte only while parsing and the output slot is free
  assign out_fire = frame_out.valid && frame_out.ready;
  assign rx.ready = (ctl_state == ST_PARSE) && (!out_valid || frame_out.ready);
  assign in_fire  = rx.valid && rx.ready;
  assign b        = rx.rx_byte;

  assign fold_a   = sum_a + b;
  assign full_len = {b, len_lo};
  assign fill_inc = CW'(fill_count + CW'(1));
  assign rd_inc   = CW'(rd_idx + CW'(1));

  // Payload store
  assign ram_wr_en   = in_fire && (parse_phase == PH_PAYLOAD);
  assign ram_rd_en   = (ctl_state == ST_READ) || (ctl_state == ST_WAIT && out_fire);
  assign ram_rd_addr = (ctl_state == ST_WAIT) ? rd_inc[AW-1:0] : rd_idx[AW-1:0];

  sfp_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_PAYLOAD)
  ) u_payload_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (fill_count[AW-1:0]),
    .wr_data (b),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Parse bytes, fold checksum and sequence the emission of a good frame
  always_comb begin
    ctl_state_next    = ctl_state;
    parse_phase_next  = parse_phase;
    class_reg_next    = class_reg;
    id_reg_next       = id_reg;
    len_lo_next       = len_lo;
    frame_length_next = frame_length;
    sum_a_next        = sum_a;
    sum_b_next        = sum_b;
    fill_count_next   = fill_count;
    rd_idx_next       = rd_idx;
    out_valid_next    = out_valid && !frame_out.ready;
    out_status_next   = out_status;
    out_flen_next     = out_flen;
    out_index_next    = out_index;
    out_data_next     = out_data;
    out_bvalid_next   = out_bvalid;
    out_last_next     = out_last;

    case (ctl_state)
      ST_PARSE: begin
        if (in_fire) begin
          case (parse_phase)
            PH_SYNC1: begin
              if (b == SYNC_FIRST) begin
                parse_phase_next = PH_SYNC2;
              end
            end
            PH_SYNC2: begin
              parse_phase_next = (b == SYNC_SECOND) ? PH_CLASS : PH_SYNC1;
            end
            PH_CLASS: begin
              class_reg_next   = b;
              sum_a_next       = b;
              sum_b_next       = b;
              parse_phase_next = PH_ID;
            end
            PH_ID: begin
              id_reg_next      = b;
              sum_a_next       = fold_a;
              sum_b_next       = sum_b + fold_a;
              parse_phase_next = PH_LEN1;
            end
            PH_LEN1: begin
              len_lo_next      = b;
              sum_a_next       = fold_a;
              sum_b_next       = sum_b + fold_a;
              parse_phase_next = PH_LEN2;
            end
            PH_LEN2: begin
              sum_a_next      = fold_a;
              sum_b_next      = sum_b + fold_a;
              fill_count_next = '0;
              if (full_len == 16'd0) begin
                frame_length_next = '0;
                parse_phase_next  = PH_CKA;
              end else if (full_len <= 16'(MAX_PAYLOAD)) begin
                frame_length_next = CW'(full_len);
                parse_phase_next  = PH_PAYLOAD;
              end else begin
                // Oversize length: report and drop the frame
                out_valid_next   = 1'b1;
                out_status_next  = STATUS_TOO_LONG;
                out_flen_next    = '0;
                out_index_next   = '0;
                out_data_next    = '0;
                out_bvalid_next  = 1'b0;
                out_last_next    = 1'b1;
                parse_phase_next = PH_SYNC1;
              end
            end
            PH_PAYLOAD: begin
              fill_count_next = fill_inc;
              sum_a_next      = fold_a;
              sum_b_next      = sum_b + fold_a;
              if (fill_inc == frame_length) begin
                parse_phase_next = PH_CKA;
              end
            end
            PH_CKA: begin
              if (b == sum_a) begin
                parse_phase_next = PH_CKB;
              end else begin
                out_valid_next   = 1'b1;
                out_status_next  = STATUS_CKSUM;
                out_flen_next    = '0;
                out_index_next   = '0;
                out_data_next    = '0;
                out_bvalid_next  = 1'b0;
                out_last_next    = 1'b1;
                parse_phase_next = PH_SYNC1;
              end
            end
            PH_CKB: begin
              parse_phase_next = PH_SYNC1;
              if (b != sum_b) begin
                out_valid_next  = 1'b1;
                out_status_next = STATUS_CKSUM;
                out_flen_next   = '0;
                out_index_next  = '0;
                out_data_next   = '0;
                out_bvalid_next = 1'b0;
                out_last_next   = 1'b1;
              end else if (frame_length == '0) begin
                // Empty good frame: one beat with no data
                out_valid_next  = 1'b1;
                out_status_next = STATUS_GOOD;
                out_flen_next   = '0;
                out_index_next  = '0;
                out_data_next   = '0;
                out_bvalid_next = 1'b0;
                out_last_next   = 1'b1;
              end else begin
                rd_idx_next    = '0;
                ctl_state_next = ST_READ;
              end
            end
            default: begin
              parse_phase_next = PH_SYNC1;
            end
          endcase
        end
      end
      ST_READ: begin
        ctl_state_next = ST_LOAD;
      end
      ST_LOAD: begin
        // Present the stored byte that the last cycle read
        out_valid_next  = 1'b1;
        out_status_next = STATUS_GOOD;
        out_flen_next   = FLEN_W'(frame_length);
        out_index_next  = INDEX_W'(rd_idx);
        out_data_next   = ram_rd_data;
        out_bvalid_next = 1'b1;
        out_last_next   = (rd_inc == frame_length);
        ctl_state_next  = ST_WAIT;
      end
      ST_WAIT: begin
        if (out_fire) begin
          if (out_last) begin
            ctl_state_next = ST_PARSE;
          end else begin
            rd_idx_next    = rd_inc;
            ctl_state_next = ST_LOAD;
          end
        end
      end
      default: begin
        ctl_state_next = ST_PARSE;
      end
    endcase
  end

  // Hold state and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_state    <= ST_PARSE;
      parse_phase  <= PH_SYNC1;
      class_reg    <= '0;
      id_reg       <= '0;
      len_lo       <= '0;
      frame_length <= '0;
      sum_a        <= '0;
      sum_b        <= '0;
      fill_count   <= '0;
      rd_idx       <= '0;
      out_valid    <= 1'b0;
    end else begin
      ctl_state    <= ctl_state_next;
      parse_phase  <= parse_phase_next;
      class_reg    <= class_reg_next;
      id_reg       <= id_reg_next;
      len_lo       <= len_lo_next;
      frame_length <= frame_length_next;
      sum_a        <= sum_a_next;
      sum_b        <= sum_b_next;
      fill_count   <= fill_count_next;
      rd_idx       <= rd_idx_next;
      out_valid    <= out_valid_next;
    end
    out_status <= out_status_next;
    out_flen   <= out_flen_next;
    out_index  <= out_index_next;
    out_data   <= out_data_next;
    out_bvalid <= out_bvalid_next;
    out_last   <= out_last_next;
  end

  // Drive the result channel
  assign frame_out.valid        = out_valid;
  assign frame_out.status       = out_status;
  assign frame_out.frame_class  = class_reg;
  assign frame_out.msg_id       = id_reg;
  assign frame_out.frame_len    = out_flen;
  assign frame_out.byte_index   = out_index;
  assign frame_out.payload_byte = out_data;
  assign frame_out.byte_valid   = out_bvalid;
  assign frame_out.last         = out_last;

  // The store is never written while a frame is being read back
  a_no_write_during_emit: assert property (@(posedge clk) disable iff (rst)
    ram_wr_en |-> (ctl_state == ST_PARSE))
    else $error("payload store written during emission");

  // A loaded result is on the channel in the next cycle
  a_load_shows_beat: assert property (@(posedge clk) disable iff (rst)
    (ctl_state == ST_LOAD) |=> frame_out.valid)
    else $error("loaded result not presented");

  // Readback index stays inside the received payload
  a_index_in_frame: assert property (@(posedge clk) disable iff (rst)
    (ctl_state != ST_PARSE) |-> (rd_idx < frame_length))
    else $error("readback index beyond frame length");

  // Fill count never passes the declared length while storing payload
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (parse_phase == PH_PAYLOAD) |-> (fill_count < frame_length))
    else $error("payload fill count past frame length");

  // Taking the final beat ends emission
  a_emit_ends_on_last: assert property (@(posedge clk) disable iff (rst)
    (ctl_state == ST_WAIT && out_fire && out_last) |=> (ctl_state == ST_PARSE))
    else $error("emission did not end after last beat");

endmodule

[rtl/sfp_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[bench/testbench.sv]
// Self-checking bench for the sync frame parser with Fletcher-8 checksum.
// Depends on sfp_pkg, sfp_byte_if, sfp_result_if and the parser RTL.
`timescale 1ns / 1ps

module testbench;
  import sfp_pkg::*;

  localparam int PAYLOAD_DEPTH = 64;
  localparam int ITEM_TARGET = 360;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT = 35;
  localparam int STEADY_FIRST = 180;
  localparam int STEADY_LAST = 260;

  typedef logic [BYTE_W-1:0] byte_q_t[$];

  typedef enum logic [3:0] {
    HUNT_FIRST, HUNT_SECOND, GET_CLASS, GET_ID, GET_LEN_LO, GET_LEN_HI,
    GET_PAYLOAD, GET_CK_A, GET_CK_B
  } tb_phase_t;

  typedef enum int {FRAME_GOOD, FRAME_BAD_CK_A, FRAME_BAD_CK_B} frame_kind_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   frame_class;
    logic [BYTE_W-1:0]   msg_id;
    logic [FLEN_W-1:0]   frame_len;
    logic [INDEX_W-1:0]  byte_index;
    logic [BYTE_W-1:0]   payload_byte;
    logic                byte_valid;
    logic                last;
  } frame_result_t;

  // Tracks the parser state byte by byte and holds the results it must emit
  class frame_scoreboard;
    tb_phase_t       phase;
    logic [7:0]      cls;
    logic [7:0]      id;
    logic [15:0]     length;
    logic [7:0]      sum_a;
    logic [7:0]      sum_b;
    int unsigned     fill;
    logic [7:0]      payload_mem [PAYLOAD_DEPTH];
    frame_result_t   expected_q[$];
    int unsigned     errors;

    function new();
      phase = HUNT_FIRST;
      cls = '0;
      id = '0;
      length = '0;
      sum_a = '0;
      sum_b = '0;
      fill = 0;
      errors = 0;
    endfunction

    function void fold(logic [7:0] b);
      sum_a = sum_a + b;
      sum_b = sum_b + sum_a;
    endfunction

    function void push_result(logic [STATUS_W-1:0] status, logic [FLEN_W-1:0] flen,
                              logic [INDEX_W-1:0] idx, logic [7:0] data,
                              logic valid, logic last);
      frame_result_t r;
      r.status = status;
      r.frame_class = cls;
      r.msg_id = id;
      r.frame_len = flen;
      r.byte_index = idx;
      r.payload_byte = data;
      r.byte_valid = valid;
      r.last = last;
      expected_q.push_back(r);
    endfunction

    // Advance the parse on one accepted beat
    function void note_byte(logic [7:0] b);
      case (phase)
        HUNT_FIRST: begin
          if (b == SYNC_FIRST) phase = HUNT_SECOND;
        end
        HUNT_SECOND: begin
          phase = (b == SYNC_SECOND) ? GET_CLASS : HUNT_FIRST;
        end
        GET_CLASS: begin
          cls = b;
          sum_a = b;
          sum_b = b;
          phase = GET_ID;
        end
        GET_ID: begin
          id = b;
          fold(b);
          phase = GET_LEN_LO;
        end
        GET_LEN_LO: begin
          length = {8'h00, b};
          fold(b);
          phase = GET_LEN_HI;
        end
        GET_LEN_HI: begin
          length[15:8] = b;
          fold(b);
          fill = 0;
          if (length == 0) begin
            phase = GET_CK_A;
          end else if (length <= PAYLOAD_DEPTH) begin
            phase = GET_PAYLOAD;
          end else begin
            push_result(STATUS_TOO_LONG, '0, '0, '0, 1'b0, 1'b1);
            phase = HUNT_FIRST;
          end
        end
        GET_PAYLOAD: begin
          if (fill < PAYLOAD_DEPTH) payload_mem[fill] = b;
          fill++;
          fold(b);
          if (fill >= length) phase = GET_CK_A;
        end
        GET_CK_A: begin
          if (b == sum_a) begin
            phase = GET_CK_B;
          end else begin
            // bad first check byte: hunt again right away
            push_result(STATUS_CKSUM, '0, '0, '0, 1'b0, 1'b1);
            phase = HUNT_FIRST;
          end
        end
        GET_CK_B: begin
          if (b != sum_b) begin
            push_result(STATUS_CKSUM, '0, '0, '0, 1'b0, 1'b1);
          end else if (length == 0) begin
            push_result(STATUS_GOOD, '0, '0, '0, 1'b0, 1'b1);
          end else begin
            for (int i = 0; i < length && i < PAYLOAD_DEPTH; i++)
              push_result(STATUS_GOOD, length[FLEN_W-1:0], i[INDEX_W-1:0],
                          payload_mem[i], 1'b1, (i + 1 == length));
          end
          phase = HUNT_FIRST;
        end
        default: phase = HUNT_FIRST;
      endcase
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected 'h%0h, actual 'h%0h", $time, name, want, got);
        errors++;
      end
    endfunction

    // Match one accepted result beat against the oldest expectation
    function void check_result(frame_result_t got);
      frame_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %p", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("status", 8'(want.status), 8'(got.status));
      compare_field("frame_class", want.frame_class, got.frame_class);
      compare_field("msg_id", want.msg_id, got.msg_id);
      compare_field("frame_len", 8'(want.frame_len), 8'(got.frame_len));
      compare_field("byte_index", 8'(want.byte_index), 8'(got.byte_index));
      compare_field("payload_byte", want.payload_byte, got.payload_byte);
      compare_field("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
      compare_field("last", 8'(want.last), 8'(got.last));
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  int unsigned cycles = 0;
  int unsigned bytes_sent = 0;
  bit steady = 1'b0;
  frame_scoreboard sb = new();

  sfp_byte_if   byte_ch();
  sfp_result_if result_ch();

  sync_frame_parser_fletcher_checksum #(
    .MAX_PAYLOAD(PAYLOAD_DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .rx(byte_ch),
    .frame_out(result_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Check accepted result beats, then pick the next ready level
  always @(posedge clk) begin
    frame_result_t got;
    got.status = result_ch.status;
    got.frame_class = result_ch.frame_class;
    got.msg_id = result_ch.msg_id;
    got.frame_len = result_ch.frame_len;
    got.byte_index = result_ch.byte_index;
    got.payload_byte = result_ch.payload_byte;
    got.byte_valid = result_ch.byte_valid;
    got.last = result_ch.last;
    if (!rst && result_ch.valid && result_ch.ready) sb.check_result(got);
    if (rst) result_ch.ready <= 1'b0;
    else result_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Bound the run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offer one beat, idling at random first, and hold it until taken
  task automatic put_byte(input logic [7:0] b);
    steady = (bytes_sent >= STEADY_FIRST) && (bytes_sent < STEADY_LAST);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.rx_byte <= b;
    do @(posedge clk); while (!byte_ch.ready);
    bytes_sent++;
    sb.note_byte(b);
  endtask

  // Drop valid and hold off until every expected result is out
  task automatic drain();
    byte_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic byte_q_t random_payload(int unsigned n);
    byte_q_t q;
    for (int i = 0; i < n; i++) q.push_back(8'($urandom_range(255)));
    return q;
  endfunction

  // Build sync, header, payload and check bytes; an oversize length ends at the header
  task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                            input logic [15:0] len, input byte_q_t payload,
                            input frame_kind_t kind);
    byte_q_t link_bytes;
    logic [7:0] ck_a;
    logic [7:0] ck_b;
    logic [7:0] flip;
    ck_a = '0;
    ck_b = '0;
    flip = 8'($urandom_range(1, 255));
    link_bytes = '{SYNC_FIRST, SYNC_SECOND, cls, id, len[7:0], len[15:8]};
    if (len <= PAYLOAD_DEPTH) begin
      foreach (payload[i]) link_bytes.push_back(payload[i]);
      for (int i = 2; i < link_bytes.size(); i++) begin
        ck_a = ck_a + link_bytes[i];
        ck_b = ck_b + ck_a;
      end
      case (kind)
        FRAME_GOOD: begin
          link_bytes.push_back(ck_a);
          link_bytes.push_back(ck_b);
        end
        FRAME_BAD_CK_A: link_bytes.push_back(ck_a ^ flip);
        FRAME_BAD_CK_B: begin
          link_bytes.push_back(ck_a);
          link_bytes.push_back(ck_b ^ flip);
        end
        default: ;
      endcase
    end
    foreach (link_bytes[i]) put_byte(link_bytes[i]);
  endtask

  initial begin : stimulus
    int unsigned frame_no;
    int unsigned pick;
    int unsigned len;
    byte_q_t none;
    byte_ch.valid <= 1'b0;
    byte_ch.rx_byte <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Repeated first sync byte: the second one is not taken as a new start
    put_byte(SYNC_FIRST);
    put_byte(SYNC_FIRST);
    put_byte(SYNC_SECOND);
    // Empty good frame
    send_frame(8'h00, 8'hFF, 16'h0000, none, FRAME_GOOD);
    // Oversize length, largest value
    send_frame(8'hFF, 8'h00, 16'hFFFF, none, FRAME_BAD_CK_A);
    // Bad first check byte, next frame follows at once
    send_frame(8'h12, 8'h34, 16'h0000, none, FRAME_BAD_CK_A);
    send_frame(8'h80, 8'h7F, 16'h0002, '{8'h00, 8'hFF}, FRAME_GOOD);
    // Bad second check byte
    send_frame(8'hAB, 8'hCD, 16'h0001, '{8'h5A}, FRAME_BAD_CK_B);
    drain();

    // Mostly well-formed frames with random content, some noise and broken frames
    frame_no = 0;
    while (bytes_sent < ITEM_TARGET) begin
      frame_no++;
      if (frame_no % 12 == 0) drain();
      pick = $urandom_range(99);
      if (frame_no == 4 || $urandom_range(99) < 3) len = PAYLOAD_DEPTH;
      else if ($urandom_range(99) < 12) len = $urandom_range(7, PAYLOAD_DEPTH - 1);
      else len = $urandom_range(0, 6);
      if (pick < 62) begin
        send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), len[15:0],
                   random_payload(len), FRAME_GOOD);
      end else if (pick < 72) begin
        send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), len[15:0],
                   random_payload(len), FRAME_BAD_CK_A);
      end else if (pick < 82) begin
        send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), len[15:0],
                   random_payload(len), FRAME_BAD_CK_B);
      end else if (pick < 88) begin
        len = $urandom_range(1) ? PAYLOAD_DEPTH + 1 : $urandom_range(PAYLOAD_DEPTH + 1, 65535);
        send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), len[15:0], none,
                   FRAME_GOOD);
      end else if (pick < 94) begin
        repeat ($urandom_range(1, 5))
          put_byte($urandom_range(3) == 0 ? SYNC_FIRST : 8'($urandom_range(255)));
      end else begin
        put_byte(SYNC_FIRST);
        put_byte(8'($urandom_range(255)));
      end
    end

    // Wait out the tail, then give the verdict
    drain();
    repeat (40) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/sfp_pkg.sv
rtl/sfp_byte_if.sv
rtl/sfp_result_if.sv
rtl/sfp_ram.sv
rtl/sync_frame_parser_fletcher_checksum.sv
bench/testbench.sv
